@@ src/hwh_pkg.sv @@
package hwh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned StepW  = 5;

  localparam logic [WordW-1:0] MixConst = 32'd1999;

  localparam logic [0:0] RegHashSeed  = 1'b0;
  localparam logic [0:0] RegTableSize = 1'b1;

  typedef struct packed {
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StWait = 3'b100
  } state_e;

endpackage

@@ src/hwh_div.sv @@
module hwh_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hwh_pkg::WordW-1:0]    dividend_i,
  input  logic [hwh_pkg::WordW-1:0]    divisor_i,
  output logic [hwh_pkg::WordW-1:0]    rem_o,
  output hwh_pkg::div_stat_t           stat_o
);

  logic [hwh_pkg::WordW-1:0] quo_q, quo_d;
  logic [hwh_pkg::WordW-1:0] rem_q, rem_d;
  logic [hwh_pkg::StepW-1:0] cnt_q, cnt_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [hwh_pkg::WordW:0]   rem_sh;
  logic [hwh_pkg::WordW+1:0] diff;

  assign rem_sh = {rem_q, quo_q[hwh_pkg::WordW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor_i};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // shift in next dividend bit, subtract when it fits
      quo_d = {quo_q[hwh_pkg::WordW-2:0], 1'b0};
      if (diff[hwh_pkg::WordW+1]) begin
        rem_d = rem_sh[hwh_pkg::WordW-1:0];
      end else begin
        rem_d = diff[hwh_pkg::WordW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign rem_o       = rem_q;
  assign stat_o.done = done_q;

endmodule

@@ src/handle_word_hash_mod.sv @@
// Handle word hash.
// Input stream (s_axis_*): one item per transfer, up to four handle bytes
// plus a byte count; tlast marks the final item of a handle.
// Output stream (m_axis_*): one hash index per handle, sent on the final item.
// Configuration: cfg_we_i writes register cfg_idx_i (0 seed, 1 table size)
// from cfg_data_i; writing the seed also restarts the running hash.
// Each item with bytes updates the running value and reduces it modulo the
// table size in a bit-serial restoring divider, one dividend bit per cycle:
// each item is accepted, stepped through the divider and written back.
// An item with zero bytes bypasses the divider.
// The hash index is registered once the divider has the last remainder
// and m_axis is free, or in the cycle after an empty final item is taken.
// A finished result waits in the output register while further items are
// taken; only a new final result stalls until the receiver takes the old one.
// Reset clears seed to zero, table size to one and empties the output.
module handle_word_hash_mod (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // word_bytes [31:0], byte_count [34:32], zero fill [39:35]
  input  logic [hwh_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // hash_index [31:0]
  output logic [hwh_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [hwh_pkg::WordW-1:0]      cfg_data_i
);

  hwh_pkg::state_e            state_q, state_d;
  logic [hwh_pkg::WordW-1:0]  seed_q, seed_d;
  logic [hwh_pkg::WordW-1:0]  size_q, size_d;
  logic [hwh_pkg::WordW-1:0]  sum_q, sum_d;
  logic                       last_q, last_d;
  logic                       out_vld_q, out_vld_d;
  logic [hwh_pkg::WordW-1:0]  out_q, out_d;

  logic [hwh_pkg::WordW-1:0]  in_word;
  logic [hwh_pkg::CountW-1:0] in_cnt;
  logic                       in_empty;
  logic [hwh_pkg::WordW-1:0]  packed_word;
  logic [hwh_pkg::WordW-1:0]  mix_val;
  logic                       out_free;
  logic                       accept;
  logic                       div_start;
  logic [hwh_pkg::WordW-1:0]  div_rem;
  hwh_pkg::div_stat_t         div_stat;

  assign in_word  = s_axis_tdata[hwh_pkg::WordW-1:0];
  assign in_cnt   = s_axis_tdata[hwh_pkg::WordW +: hwh_pkg::CountW];
  assign in_empty = (in_cnt == '0);
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    if (in_cnt[2]) begin
      packed_word = in_word;
    end else begin
      case (in_cnt[1:0])
        2'd1:    packed_word = {24'd0, in_word[7:0]};
        2'd2:    packed_word = {16'd0, in_word[7:0], in_word[15:8]};
        2'd3:    packed_word = {8'd0, in_word[7:0], in_word[15:8], in_word[23:16]};
        default: packed_word = in_word;
      endcase
    end
  end

  assign mix_val = {sum_q[hwh_pkg::WordW-2:0], 1'b0} + sum_q
                 + {packed_word[hwh_pkg::WordW-3:0], 2'b00} + packed_word
                 + hwh_pkg::MixConst;

  assign s_axis_tready = (state_q == hwh_pkg::StIdle)
                       && !(s_axis_tlast && in_empty && !out_free);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign div_start = accept && !in_empty;

  hwh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mix_val),
    .divisor_i  (size_q),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d   = state_q;
    seed_d    = seed_q;
    size_d    = size_q;
    sum_d     = sum_q;
    last_d    = last_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      hwh_pkg::StIdle: begin
        if (accept) begin
          last_d = s_axis_tlast;
          if (!in_empty) begin
            state_d = hwh_pkg::StDiv;
          end else if (s_axis_tlast) begin
            out_d     = sum_q;
            out_vld_d = 1'b1;
            sum_d     = seed_q;
          end
        end
      end
      hwh_pkg::StDiv, hwh_pkg::StWait: begin
        if (div_stat.done || state_q == hwh_pkg::StWait) begin
          if (!last_q) begin
            sum_d   = div_rem;
            state_d = hwh_pkg::StIdle;
          end else if (out_free) begin
            out_d     = div_rem;
            out_vld_d = 1'b1;
            sum_d     = seed_q;
            state_d   = hwh_pkg::StIdle;
          end else begin
            // hold remainder until the output slot drains
            state_d = hwh_pkg::StWait;
          end
        end
      end
      default: begin
        state_d = hwh_pkg::StIdle;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        hwh_pkg::RegHashSeed: begin
          seed_d = cfg_data_i;
          sum_d  = cfg_data_i;
        end
        hwh_pkg::RegTableSize: begin
          size_d = cfg_data_i;
        end
        default: begin
          size_d = size_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hwh_pkg::StIdle;
      seed_q    <= '0;
      size_q    <= 32'd1;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      seed_q    <= seed_d;
      size_q    <= size_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
